[rtl/vps_pkg.sv]
package vps_pkg;

    localparam int IN_W   = 24;
    localparam int CIN_W  = 32;
    localparam int PNT_W  = 25;
    localparam int MAG_W  = 24;
    localparam int SQ_W   = 48;
    localparam int SUM_W  = 40;
    localparam int SQS_W  = 63;
    localparam int DIST_W = 49;
    localparam int OUT_W  = 48;
    localparam int CNT_W  = 16;
    localparam int DVD_W  = 64;
    localparam int FRAC_SHIFT = 8;

    localparam logic [1:0] KIND_MEAN = 2'd0;
    localparam logic [1:0] KIND_MSQ  = 2'd1;
    localparam logic [1:0] KIND_FAR  = 2'd2;
    localparam logic [1:0] KIND_NEAR = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQR  = 6'b000010,
        S_UPD  = 6'b000100,
        S_LOAD = 6'b001000,
        S_DIVS = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

[rtl/voxel_point_statistics.sv]
// Channel | Handshake             | Fields
// in      | in_valid / in_stall   | coord_x, coord_y, coord_z
// out     | out_valid / out_stall | kind, value_x, value_y, value_z, point_count, last
//
// Each input word: three squaring steps on one multiplier and one update step (both skipped
// once MAX_POINTS words are counted), then six rounding divisions on one shared radix-4
// divider, then four output words, one per cycle unless out_stall holds them.
// in_stall is high from the accept until the fourth output word is taken.
// Reset clears the count, sums and extreme points; the first word sets both extremes.
module voxel_point_statistics #(
    parameter int MAX_POINTS = 65535,
    parameter int COORD_BITS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [vps_pkg::IN_W-1:0]  coord_x,
    input  logic signed [vps_pkg::IN_W-1:0]  coord_y,
    input  logic signed [vps_pkg::IN_W-1:0]  coord_z,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  kind,
    output logic signed [vps_pkg::OUT_W-1:0] value_x,
    output logic signed [vps_pkg::OUT_W-1:0] value_y,
    output logic signed [vps_pkg::OUT_W-1:0] value_z,
    output logic [vps_pkg::CNT_W-1:0]   point_count,
    output logic                        last
);
    import vps_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SH = CIN_W - COORD_BITS;

    state_t                  state_reg;
    logic [1:0]              ax_reg;
    logic                    phase_reg;
    logic [1:0]              kind_reg;
    logic                    out_valid_reg;
    logic [CW-1:0]           count_reg;
    logic                    neg_reg;
    logic [PNT_W-1:0]        pt_reg    [3];
    logic [SQ_W-1:0]         sq_reg    [3];
    logic [SUM_W-1:0]        csum_reg  [3];
    logic [SQS_W-1:0]        ssum_reg  [3];
    logic [PNT_W-1:0]        far_reg   [3];
    logic [PNT_W-1:0]        near_reg  [3];
    logic [DIST_W-1:0]       fard_reg;
    logic [DIST_W-1:0]       neard_reg;
    logic [OUT_W-1:0]        mean_reg  [3];
    logic [OUT_W-1:0]        msq_reg   [3];

    logic [PNT_W-1:0]        pt_in     [3];
    logic [PNT_W-1:0]        pt_abs;
    logic [SQ_W-1:0]         sq_cur;
    logic [SUM_W-1:0]        sum_sel;
    logic [OUT_W-1:0]        mean_num;
    logic [OUT_W-1:0]        mean_mag;
    logic [DVD_W-1:0]        dividend;
    logic [DIST_W+1:0]       dist_wide;
    logic [DIST_W-1:0]       sq_dist;
    logic [OUT_W-1:0]        quotient;
    logic [OUT_W-1:0]        signed_q;
    logic                    first;
    logic                    accept;
    logic                    out_take;
    logic                    full;
    div_ctl_t                div_ctl;
    div_sts_t                div_sts;

    function automatic logic [PNT_W-1:0] sext_in(input logic [IN_W-1:0] raw);
        logic [CIN_W-1:0]        wide;
        logic signed [CIN_W-1:0] ext;
        wide = CIN_W'(raw);
        ext  = $signed(wide << SH) >>> SH;
        return PNT_W'(ext);
    endfunction

    function automatic logic [OUT_W-1:0] scale(input logic [PNT_W-1:0] p);
        return {{(OUT_W - FRAC_SHIFT - PNT_W){p[PNT_W-1]}}, p, FRAC_SHIFT'(0)};
    endfunction

    assign pt_in[0] = sext_in(coord_x);
    assign pt_in[1] = sext_in(coord_y);
    assign pt_in[2] = sext_in(coord_z);

    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign full     = count_reg == CW'(MAX_POINTS);
    assign first    = count_reg == '0;

    always_comb
    begin
        pt_abs    = pt_reg[ax_reg][PNT_W-1] ? PNT_W'(-pt_reg[ax_reg]) : pt_reg[ax_reg];
        sq_cur    = SQ_W'(pt_abs[MAG_W-1:0]) * SQ_W'(pt_abs[MAG_W-1:0]);
        sum_sel   = csum_reg[ax_reg];
        mean_num  = {sum_sel, FRAC_SHIFT'(0)};
        mean_mag  = sum_sel[SUM_W-1] ? OUT_W'(-mean_num) : mean_num;
        dividend  = phase_reg ? DVD_W'(ssum_reg[ax_reg]) : DVD_W'(mean_mag);
        dist_wide = (DIST_W+2)'(sq_reg[0]) + (DIST_W+2)'(sq_reg[1])
                  + (DIST_W+2)'(sq_reg[2]);
        sq_dist   = dist_wide[DIST_W-1:0];
        signed_q  = (!phase_reg && neg_reg) ? OUT_W'(-quotient) : quotient;
    end

    assign div_ctl.start = state_reg == S_LOAD;

    vps_div #(
        .CW(CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (dividend),
        .divisor  (count_reg),
        .sts      (div_sts),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pt_reg[i] <= pt_in[i];
            end
        end
        if (state_reg == S_SQR)
        begin
            sq_reg[ax_reg] <= sq_cur;
        end
        if (state_reg == S_LOAD)
        begin
            neg_reg <= sum_sel[SUM_W-1];
        end
        if (state_reg == S_DIVS && div_sts.done)
        begin
            if (phase_reg)
            begin
                msq_reg[ax_reg] <= signed_q;
            end
            else
            begin
                mean_reg[ax_reg] <= signed_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ax_reg        <= '0;
            phase_reg     <= 1'b0;
            kind_reg      <= KIND_MEAN;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            fard_reg      <= '0;
            neard_reg     <= '0;
            for (int i = 0; i < 3; i++)
            begin
                csum_reg[i] <= '0;
                ssum_reg[i] <= '0;
                far_reg[i]  <= '0;
                near_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ax_reg    <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= full ? S_LOAD : S_SQR;
                    end
                end
                S_SQR:
                begin
                    csum_reg[ax_reg] <= csum_reg[ax_reg]
                                      + {{(SUM_W-PNT_W){pt_reg[ax_reg][PNT_W-1]}},
                                         pt_reg[ax_reg]};
                    if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= '0;
                        state_reg <= S_UPD;
                    end
                    else
                    begin
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                S_UPD:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        ssum_reg[i] <= ssum_reg[i] + SQS_W'(sq_reg[i]);
                    end
                    if (first || sq_dist > fard_reg)
                    begin
                        fard_reg <= sq_dist;
                        for (int i = 0; i < 3; i++)
                        begin
                            far_reg[i] <= pt_reg[i];
                        end
                    end
                    if (first || sq_dist < neard_reg)
                    begin
                        neard_reg <= sq_dist;
                        for (int i = 0; i < 3; i++)
                        begin
                            near_reg[i] <= pt_reg[i];
                        end
                    end
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    state_reg <= S_DIVS;
                end
                S_DIVS:
                begin
                    if (div_sts.done)
                    begin
                        if (ax_reg == 2'd2)
                        begin
                            ax_reg <= '0;
                            if (phase_reg)
                            begin
                                kind_reg      <= KIND_MEAN;
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_EMIT;
                            end
                            else
                            begin
                                phase_reg <= 1'b1;
                                state_reg <= S_LOAD;
                            end
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_take)
                    begin
                        if (kind_reg == KIND_NEAR)
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            kind_reg <= kind_reg + 2'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (kind_reg)
            KIND_MEAN:
            begin
                value_x = mean_reg[0];
                value_y = mean_reg[1];
                value_z = mean_reg[2];
            end
            KIND_MSQ:
            begin
                value_x = msq_reg[0];
                value_y = msq_reg[1];
                value_z = msq_reg[2];
            end
            KIND_FAR:
            begin
                value_x = scale(far_reg[0]);
                value_y = scale(far_reg[1]);
                value_z = scale(far_reg[2]);
            end
            default:
            begin
                value_x = scale(near_reg[0]);
                value_y = scale(near_reg[1]);
                value_z = scale(near_reg[2]);
            end
        endcase
    end

    assign in_stall    = state_reg != S_IDLE;
    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign point_count = CNT_W'(count_reg);
    assign last        = kind_reg == KIND_NEAR;

endmodule

[rtl/vps_div.sv]
module vps_div #(
    parameter int CW = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vps_pkg::div_ctl_t          ctl,
    input  logic [vps_pkg::DVD_W-1:0]  dividend,
    input  logic [CW-1:0]              divisor,
    output vps_pkg::div_sts_t          sts,
    output logic [vps_pkg::OUT_W-1:0]  quotient
);
    import vps_pkg::*;

    localparam int STEPS = DVD_W / 2;
    localparam int SW    = $clog2(STEPS);

    logic [DVD_W-1:0] dvd_reg;
    logic [CW-1:0]    rem_reg;
    logic [OUT_W-1:0] quot_reg;
    logic [SW-1:0]    step_reg;
    logic             busy_reg;
    logic             rnd_reg;
    logic             done_reg;

    logic [CW:0]      dsr;
    logic [CW:0]      r1;
    logic [CW:0]      r2;
    logic             ge1;
    logic             ge2;
    logic [CW-1:0]    rem1;
    logic [CW-1:0]    rem2;
    logic [DVD_W-1:0] dvd1;
    logic [DVD_W-1:0] dvd2;
    logic             up;
    logic [OUT_W-1:0] qsum;

    always_comb
    begin
        dsr  = {1'b0, divisor};
        r1   = {rem_reg, dvd_reg[DVD_W-1]};
        ge1  = r1 >= dsr;
        rem1 = ge1 ? CW'(r1 - dsr) : CW'(r1);
        dvd1 = {dvd_reg[DVD_W-2:0], ge1};
        r2   = {rem1, dvd1[DVD_W-1]};
        ge2  = r2 >= dsr;
        rem2 = ge2 ? CW'(r2 - dsr) : CW'(r2);
        dvd2 = {dvd1[DVD_W-2:0], ge2};
        up   = {rem_reg, 1'b0} >= dsr;
        qsum = dvd_reg[OUT_W-1:0] + OUT_W'(up);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd2;
            rem_reg <= rem2;
        end
        if (rnd_reg)
        begin
            quot_reg <= qsum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            step_reg <= '0;
            busy_reg <= 1'b1;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + SW'(1);
            if (step_reg == SW'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
                rnd_reg  <= 1'b1;
            end
        end
        else if (rnd_reg)
        begin
            rnd_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign sts.busy = busy_reg | rnd_reg;
    assign sts.done = done_reg;
    assign quotient = quot_reg;

endmodule

[rtl/vps_check.sv]
module vps_check (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [1:0]                       kind,
    input logic                             last
);
    import vps_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block took a word while not stalling afterwards");

    a_stall_while_output: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while output words pending");

    a_kind_advance: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind != KIND_NEAR |=>
            out_valid && kind == $past(kind) + 2'd1)
        else $error("output words out of order");

    a_end_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> !out_valid)
        else $error("extra output word after last");

endmodule

bind voxel_point_statistics vps_check u_vps_check (.*);
